@@ rtl/core/lpfd_pkg.sv @@
// Shared types, constants and codes of the length-prefixed frame decoder.
`timescale 1ns / 1ps

package lpfd_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int MAGIC_END    = 4;
    localparam int VERSION_END  = 6;
    localparam int TYPE_END     = 8;
    localparam int LENGTH_END   = 12;
    localparam int HDR_COUNT_W  = $clog2(HEADER_BYTES);
    localparam int NUM_TYPES    = 5;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_MAGIC   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD_LEN  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_A      = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_E      = 8'd7;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_BAD_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_BAD_VERSION = 2'd1;
    localparam logic [1:0] ERR_BAD_TYPE    = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE   = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALT    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0]                expected_magic;
        logic [15:0]                expected_version;
        logic [31:0]                max_payload_len;
        logic [NUM_TYPES-1:0][15:0] type_codes;
    } cfg_t;

    typedef struct packed {
        logic       fail;
        logic [1:0] code;
    } chk_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] msg_type;
        logic [63:0] request_tag;
        logic [31:0] payload_len;
        logic [7:0]  data_byte;
        logic [1:0]  error_code;
        logic        frame_last;
    } result_t;

endpackage

@@ rtl/core/lpfd_if.sv @@
// Channel interfaces of the frame decoder: byte stream, results and configuration writes.
`timescale 1ns / 1ps

interface lpfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface lpfd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [63:0] request_tag;
    logic [31:0] payload_len;
    logic [7:0]  data_byte;
    logic [1:0]  error_code;
    logic        frame_last;

    modport source (
        output valid, output kind, output msg_type, output request_tag,
        output payload_len, output data_byte, output error_code, output frame_last,
        input ready
    );
    modport sink (
        input valid, input kind, input msg_type, input request_tag,
        input payload_len, input data_byte, input error_code, input frame_last,
        output ready
    );
endinterface

interface lpfd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lpfd_pkg::CFG_INDEX_W-1:0] index;
    logic [lpfd_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/lpfd_hdr_check.sv @@
// Header check: magic, version, known type and length limit, in order of priority.
`timescale 1ns / 1ps

module lpfd_hdr_check (
    input  lpfd_pkg::cfg_t cfg_regs,
    input  logic [31:0]    magic,
    input  logic [15:0]    version,
    input  logic [15:0]    msg_type,
    input  logic [31:0]    length,
    output lpfd_pkg::chk_t chk
);

    logic type_known;

    always_comb
    begin
        type_known = 1'b0;
        for (int i = 0; i < lpfd_pkg::NUM_TYPES; i++)
        begin
            if (cfg_regs.type_codes[i] == msg_type)
            begin
                type_known = 1'b1;
            end
        end
    end

    always_comb
    begin
        chk.fail = 1'b1;
        chk.code = lpfd_pkg::ERR_BAD_MAGIC;
        if (magic != cfg_regs.expected_magic)
        begin
            chk.code = lpfd_pkg::ERR_BAD_MAGIC;
        end
        else if (version != cfg_regs.expected_version)
        begin
            chk.code = lpfd_pkg::ERR_BAD_VERSION;
        end
        else if (!type_known)
        begin
            chk.code = lpfd_pkg::ERR_BAD_TYPE;
        end
        else if (length > cfg_regs.max_payload_len)
        begin
            chk.code = lpfd_pkg::ERR_TOO_LARGE;
        end
        else
        begin
            chk.fail = 1'b0;
        end
    end

endmodule

@@ rtl/core/length_prefixed_frame_decoder.sv @@
// Top level of the length-prefixed frame decoder.
// The decoder takes one byte per clock cycle in a steady stream: each byte is captured in an
// input register and decoded into the result register once that register is empty or being read,
// so every result is offered from a register, and a request is taken on every cycle
// while the result side keeps up. The first 20 bytes of a frame form a big-endian header (magic,
// version, type, length, request id); after the last of them a header result or an error
// result is given, then one result per payload byte with frame_last on the final one. After
// an error every further byte is accepted and dropped until reset. Configuration writes are
// always accepted and must be made only while no bytes are in flight.
`timescale 1ns / 1ps

module length_prefixed_frame_decoder (
    input  logic               clk,
    input  logic               rst_n,
    lpfd_byte_if.sink          stream,
    lpfd_res_if.source         result,
    lpfd_cfg_if.sink           cfg
);

    lpfd_pkg::cfg_t  cfg_reg;

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            advance;

    lpfd_pkg::phase_t                   phase_reg, phase_next;
    logic [lpfd_pkg::HDR_COUNT_W-1:0]   count_reg, count_next;
    logic [31:0]                        magic_reg, magic_next;
    logic [15:0]                        version_reg, version_next;
    logic [15:0]                        type_reg, type_next;
    logic [31:0]                        length_reg, length_next;
    logic [63:0]                        tag_reg, tag_next;
    logic [31:0]                        left_reg, left_next;

    logic                               res_valid_reg, res_valid_next;
    lpfd_pkg::result_t                  res_reg, res_next;
    logic                               produce;
    lpfd_pkg::chk_t                     chk;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lpfd_pkg::REG_EXPECTED_MAGIC:
                begin
                    cfg_reg.expected_magic <= cfg.wdata;
                end
                lpfd_pkg::REG_EXPECTED_VERSION:
                begin
                    cfg_reg.expected_version <= cfg.wdata[15:0];
                end
                lpfd_pkg::REG_MAX_PAYLOAD_LEN:
                begin
                    cfg_reg.max_payload_len <= cfg.wdata;
                end
                default:
                begin
                    if (cfg.index inside
                        {[lpfd_pkg::REG_TYPE_CODE_A : lpfd_pkg::REG_TYPE_CODE_E]})
                    begin
                        cfg_reg.type_codes[3'(cfg.index - lpfd_pkg::REG_TYPE_CODE_A)]
                            <= cfg.wdata[15:0];
                    end
                end
            endcase
        end
    end

    // Input register: refilled whenever its byte moves on or it is empty.
    assign advance      = in_valid_reg && (!res_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg <= stream.in_byte;
        end
    end

    lpfd_hdr_check u_check (
        .cfg_regs (cfg_reg),
        .magic    (magic_next),
        .version  (version_next),
        .msg_type (type_next),
        .length   (length_next),
        .chk      (chk)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        tag_next     = tag_reg;
        left_next    = left_reg;
        produce      = 1'b0;
        res_next     = '0;

        case (phase_reg)
            lpfd_pkg::PH_HEADER:
            begin
                if (count_reg < lpfd_pkg::HDR_COUNT_W'(lpfd_pkg::MAGIC_END))
                begin
                    magic_next = {magic_reg[23:0], in_byte_reg};
                end
                else if (count_reg < lpfd_pkg::HDR_COUNT_W'(lpfd_pkg::VERSION_END))
                begin
                    version_next = {version_reg[7:0], in_byte_reg};
                end
                else if (count_reg < lpfd_pkg::HDR_COUNT_W'(lpfd_pkg::TYPE_END))
                begin
                    type_next = {type_reg[7:0], in_byte_reg};
                end
                else if (count_reg < lpfd_pkg::HDR_COUNT_W'(lpfd_pkg::LENGTH_END))
                begin
                    length_next = {length_reg[23:0], in_byte_reg};
                end
                else
                begin
                    tag_next = {tag_reg[55:0], in_byte_reg};
                end

                if (count_reg != lpfd_pkg::HDR_COUNT_W'(lpfd_pkg::HEADER_BYTES - 1))
                begin
                    count_next = count_reg + lpfd_pkg::HDR_COUNT_W'(1);
                end
                else
                begin
                    count_next = '0;
                    produce    = 1'b1;
                    if (chk.fail)
                    begin
                        res_next.kind       = lpfd_pkg::KIND_ERROR;
                        res_next.error_code = chk.code;
                        res_next.frame_last = 1'b1;
                        phase_next          = lpfd_pkg::PH_HALT;
                    end
                    else
                    begin
                        res_next.kind        = lpfd_pkg::KIND_HEADER;
                        res_next.msg_type    = type_next;
                        res_next.request_tag = tag_next;
                        res_next.payload_len = length_next;
                        if (length_next == '0)
                        begin
                            res_next.frame_last = 1'b1;
                        end
                        else
                        begin
                            left_next  = length_next;
                            phase_next = lpfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            lpfd_pkg::PH_PAYLOAD:
            begin
                produce            = 1'b1;
                res_next.kind      = lpfd_pkg::KIND_PAYLOAD;
                res_next.data_byte = in_byte_reg;
                left_next          = left_reg - 32'd1;
                if (left_reg == 32'd1)
                begin
                    res_next.frame_last = 1'b1;
                    phase_next          = lpfd_pkg::PH_HEADER;
                    count_next          = '0;
                end
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = produce;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lpfd_pkg::PH_HEADER;
            count_reg     <= '0;
            magic_reg     <= '0;
            version_reg   <= '0;
            type_reg      <= '0;
            length_reg    <= '0;
            tag_reg       <= '0;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                magic_reg   <= magic_next;
                version_reg <= version_next;
                type_reg    <= type_next;
                length_reg  <= length_next;
                tag_reg     <= tag_next;
                left_reg    <= left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.kind        = res_reg.kind;
    assign result.msg_type    = res_reg.msg_type;
    assign result.request_tag = res_reg.request_tag;
    assign result.payload_len = res_reg.payload_len;
    assign result.data_byte   = res_reg.data_byte;
    assign result.error_code  = res_reg.error_code;
    assign result.frame_last  = res_reg.frame_last;

endmodule

@@ test/tb.sv @@
// Self-checking testbench of the frame decoder: directed and random frames against a byte-level model.
`timescale 1ns / 1ps

module tb;

    localparam int PAYLOAD_CAP = 24;
    localparam int DRAIN_SLACK = 8;
    localparam int HOLD_CYCLES = 80;

    logic clk;
    logic rst_n;

    lpfd_byte_if byte_ch ();
    lpfd_res_if  result_ch ();
    lpfd_cfg_if  cfg_ch ();

    length_prefixed_frame_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic [7:0]        stream_bytes[$];
    lpfd_pkg::result_t frame_results[$];
    int                bytes_queued = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_left = 0;
    int                mismatch_count = 0;
    lpfd_pkg::cfg_t    stim_cfg;

    lpfd_pkg::cfg_t                   reg_copy;
    lpfd_pkg::phase_t                 dec_phase;
    logic [lpfd_pkg::HDR_COUNT_W-1:0] hdr_pos;
    logic [31:0]                      magic_sr;
    logic [15:0]                      version_sr;
    logic [15:0]                      type_sr;
    logic [31:0]                      length_sr;
    logic [63:0]                      tag_sr;
    logic [31:0]                      payload_left;

    function automatic bit type_listed(input lpfd_pkg::cfg_t c, input logic [15:0] t);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < lpfd_pkg::NUM_TYPES; i++)
        begin
            if (c.type_codes[i] == t)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void apply_write(input logic [lpfd_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [lpfd_pkg::CFG_DATA_W-1:0] data);
        if (idx == lpfd_pkg::REG_EXPECTED_MAGIC)
            reg_copy.expected_magic = data;
        else if (idx == lpfd_pkg::REG_EXPECTED_VERSION)
            reg_copy.expected_version = data[15:0];
        else if (idx == lpfd_pkg::REG_MAX_PAYLOAD_LEN)
            reg_copy.max_payload_len = data;
        else if (idx >= lpfd_pkg::REG_TYPE_CODE_A && idx <= lpfd_pkg::REG_TYPE_CODE_E)
            reg_copy.type_codes[3'(idx - lpfd_pkg::REG_TYPE_CODE_A)] = data[15:0];
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        lpfd_pkg::result_t r;
        r = '0;
        if (dec_phase == lpfd_pkg::PH_HEADER)
        begin
            if (hdr_pos < lpfd_pkg::MAGIC_END)
                magic_sr = {magic_sr[23:0], b};
            else if (hdr_pos < lpfd_pkg::VERSION_END)
                version_sr = {version_sr[7:0], b};
            else if (hdr_pos < lpfd_pkg::TYPE_END)
                type_sr = {type_sr[7:0], b};
            else if (hdr_pos < lpfd_pkg::LENGTH_END)
                length_sr = {length_sr[23:0], b};
            else
                tag_sr = {tag_sr[55:0], b};
            if (hdr_pos != lpfd_pkg::HEADER_BYTES - 1)
            begin
                hdr_pos = hdr_pos + 1'b1;
                return;
            end
            hdr_pos = '0;
            r.kind = lpfd_pkg::KIND_ERROR;
            r.frame_last = 1'b1;
            if (magic_sr != reg_copy.expected_magic)
                r.error_code = lpfd_pkg::ERR_BAD_MAGIC;
            else if (version_sr != reg_copy.expected_version)
                r.error_code = lpfd_pkg::ERR_BAD_VERSION;
            else if (!type_listed(reg_copy, type_sr))
                r.error_code = lpfd_pkg::ERR_BAD_TYPE;
            else if (length_sr > reg_copy.max_payload_len)
                r.error_code = lpfd_pkg::ERR_TOO_LARGE;
            else
            begin
                r.kind = lpfd_pkg::KIND_HEADER;
                r.msg_type = type_sr;
                r.request_tag = tag_sr;
                r.payload_len = length_sr;
                r.frame_last = (length_sr == 0);
                payload_left = length_sr;
                if (length_sr != 0)
                    dec_phase = lpfd_pkg::PH_PAYLOAD;
            end
            if (r.kind == lpfd_pkg::KIND_ERROR)
                dec_phase = lpfd_pkg::PH_HALT;
            frame_results.insert(frame_results.size(), r);
        end
        else if (dec_phase == lpfd_pkg::PH_PAYLOAD)
        begin
            r.kind = lpfd_pkg::KIND_PAYLOAD;
            r.data_byte = b;
            payload_left = payload_left - 1;
            if (payload_left == 0)
            begin
                r.frame_last = 1'b1;
                dec_phase = lpfd_pkg::PH_HEADER;
                hdr_pos = '0;
            end
            frame_results.insert(frame_results.size(), r);
        end
    endfunction

    function automatic void flag(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
            flag($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    function automatic void check_result();
        lpfd_pkg::result_t want;
        if (frame_results.size() == 0)
        begin
            flag($sformatf("result of kind %0d with none outstanding", result_ch.kind));
            return;
        end
        want = frame_results.pop_front();
        compare_field("kind", want.kind, result_ch.kind);
        compare_field("msg_type", want.msg_type, result_ch.msg_type);
        compare_field("request_tag", want.request_tag, result_ch.request_tag);
        compare_field("payload_len", want.payload_len, result_ch.payload_len);
        compare_field("data_byte", want.data_byte, result_ch.data_byte);
        compare_field("error_code", want.error_code, result_ch.error_code);
        compare_field("frame_last", want.frame_last, result_ch.frame_last);
    endfunction

    function automatic lpfd_pkg::cfg_t random_cfg();
        lpfd_pkg::cfg_t c;
        c.expected_magic = $urandom;
        c.expected_version = 16'($urandom);
        c.max_payload_len = $urandom_range(1, PAYLOAD_CAP);
        for (int i = 0; i < lpfd_pkg::NUM_TYPES; i++)
        begin
            c.type_codes[i] = 16'($urandom);
        end
        return c;
    endfunction

    task automatic push_frame(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [15:0] mtype, input logic [31:0] len,
                              input logic [63:0] tag, input int body, input bit stripes);
        logic [159:0] hdr;
        hdr = {magic, ver, mtype, len, tag};
        for (int i = lpfd_pkg::HEADER_BYTES - 1; i >= 0; i--)
        begin
            stream_bytes.insert(stream_bytes.size(), hdr[i * 8 +: 8]);
        end
        for (int k = 0; k < body; k++)
        begin
            stream_bytes.insert(stream_bytes.size(),
                                stripes ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom));
        end
        bytes_queued += lpfd_pkg::HEADER_BYTES + body;
    endtask

    task automatic run_frames(input int n, input int idle, input int stall);
        int          goal;
        logic [31:0] lim;
        logic [31:0] len;
        logic [63:0] tag;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        goal = bytes_queued + n;
        while (bytes_queued < goal)
        begin
            lim = (stim_cfg.max_payload_len < PAYLOAD_CAP) ? stim_cfg.max_payload_len
                                                            : PAYLOAD_CAP;
            len = ($urandom_range(0, 7) == 0) ? lim : $urandom_range(0, lim);
            case ($urandom_range(0, 7))
                0:       tag = '0;
                1:       tag = '1;
                default: tag = {$urandom, $urandom};
            endcase
            push_frame(stim_cfg.expected_magic, stim_cfg.expected_version,
                       stim_cfg.type_codes[$urandom_range(0, lpfd_pkg::NUM_TYPES - 1)],
                       len, tag, len, 1'b0);
        end
    endtask

    task automatic wait_drain();
        while (stream_bytes.size() != 0 || byte_ch.valid || frame_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lpfd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lpfd_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic load_config(input lpfd_pkg::cfg_t c);
        write_reg(lpfd_pkg::REG_EXPECTED_MAGIC, c.expected_magic);
        write_reg(lpfd_pkg::REG_EXPECTED_VERSION, {16'($urandom), c.expected_version});
        write_reg(lpfd_pkg::REG_MAX_PAYLOAD_LEN, c.max_payload_len);
        for (int i = 0; i < lpfd_pkg::NUM_TYPES; i++)
        begin
            write_reg(lpfd_pkg::CFG_INDEX_W'(lpfd_pkg::REG_TYPE_CODE_A + i),
                      {16'($urandom), c.type_codes[i]});
        end
        cfg_ch.valid <= 1'b0;
        stim_cfg = c;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.in_byte <= '0;
        end
        else if (!byte_ch.valid || byte_ch.ready)
        begin
            if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                byte_ch.valid <= 1'b1;
                byte_ch.in_byte <= stream_bytes.pop_front();
            end
            else
            begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_copy = '0;
            dec_phase = lpfd_pkg::PH_HEADER;
            hdr_pos = '0;
            magic_sr = '0;
            version_sr = '0;
            type_sr = '0;
            length_sr = '0;
            tag_sr = '0;
            payload_left = '0;
            frame_results.delete();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_write(cfg_ch.index, cfg_ch.wdata);
            if (byte_ch.valid && byte_ch.ready)
                decode_byte(byte_ch.in_byte);
            if (result_ch.valid && result_ch.ready)
                check_result();
        end
    end

    initial
    begin
        lpfd_pkg::cfg_t setting;
        logic [63:0]    tag;
        logic [31:0]    bad_magic;
        logic [31:0]    bad_len;
        logic [15:0]    bad_ver;
        logic [15:0]    bad_type;
        logic [1:0]     bad_check;
        int             waited;

        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.in_byte = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // With the registers at their reset values only empty headers with zero magic, version and type are accepted.
        stim_cfg = '0;
        push_frame('0, '0, '0, '0, {64{1'b1}}, 0, 1'b0);
        push_frame('0, '0, '0, '0, 64'd0, 0, 1'b0);
        wait_drain();

        setting.expected_magic = '1;
        setting.expected_version = '1;
        setting.max_payload_len = '1;
        setting.type_codes = {16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF};
        write_reg(lpfd_pkg::CFG_INDEX_W'($urandom_range(lpfd_pkg::REG_TYPE_CODE_E + 1, 255)),
                  $urandom);
        load_config(setting);
        for (int i = 0; i < lpfd_pkg::NUM_TYPES; i++)
        begin
            tag = (i == 0) ? {64{1'b1}} : (i == 1) ? 64'd0 : {$urandom, $urandom};
            push_frame(stim_cfg.expected_magic, stim_cfg.expected_version,
                       stim_cfg.type_codes[i], i, tag, i, 1'b1);
        end
        wait_drain();

        load_config(random_cfg());
        run_frames(220, 0, 0);
        wait_drain();
        run_frames(220, 76, 0);
        wait_drain();
        run_frames(220, 0, 76);
        wait_drain();
        run_frames(220, 19, 19);
        wait_drain();

        // The result side holds off while bytes keep coming, so the decoder backs up.
        run_frames(150, 0, 0);
        @(posedge clk);
        hold_left <= HOLD_CYCLES;
        wait_drain();

        setting = random_cfg();
        setting.expected_magic = '0;
        setting.expected_version = '0;
        setting.max_payload_len = '0;
        load_config(setting);
        run_frames(100, 19, 19);
        wait_drain();

        load_config(random_cfg());
        run_frames(120, 19, 19);

        // A single faulty header ends the run, since the decoder halts until reset.
        bad_magic = stim_cfg.expected_magic;
        bad_ver = stim_cfg.expected_version;
        bad_type = stim_cfg.type_codes[$urandom_range(0, lpfd_pkg::NUM_TYPES - 1)];
        bad_len = 0;
        bad_check = 2'($urandom);
        case (bad_check)
            lpfd_pkg::ERR_BAD_MAGIC:   bad_magic = bad_magic ^ ($urandom | 32'h1);
            lpfd_pkg::ERR_BAD_VERSION: bad_ver = bad_ver ^ (16'($urandom) | 16'h1);
            lpfd_pkg::ERR_BAD_TYPE:
            begin
                do
                    bad_type = 16'($urandom);
                while (type_listed(stim_cfg, bad_type));
            end
            lpfd_pkg::ERR_TOO_LARGE:
                bad_len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                        : stim_cfg.max_payload_len + 1 + $urandom_range(0, 1000);
            default:
                bad_len = 0;
        endcase
        push_frame(bad_magic, bad_ver, bad_type, bad_len, {$urandom, $urandom}, 0, 1'b0);
        repeat (30) stream_bytes.insert(stream_bytes.size(), 8'($urandom));

        while (stream_bytes.size() != 0 || byte_ch.valid)
            @(posedge clk);
        waited = 0;
        while (frame_results.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (frame_results.size() != 0)
            flag($sformatf("%0d expected results never arrived", frame_results.size()));
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
